FILE: hdl/pwb_pkg.sv
// Shared types and constants for the perspective warp unit.
// No dependencies; every other file but pwb_ram imports this package.
`timescale 1ns / 1ps

package pwb_pkg;

  localparam int COEF_W    = 48;
  localparam int NUM_COEF  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 10;
  localparam int CHAN_W    = 8;
  localparam int SUM_W     = 64;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Register indexes of the coefficient bank.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_XX = 3'd0,
    REG_XY = 3'd1,
    REG_X0 = 3'd2,
    REG_YX = 3'd3,
    REG_YY = 3'd4,
    REG_Y0 = 3'd5,
    REG_WX = 3'd6,
    REG_WY = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_REQ  = 1'b1
  } kind_t;

  // 1.0 with 32 fraction bits.
  localparam coef_t COEF_ONE = 48'sh0001_0000_0000;
  localparam logic signed [SUM_W-1:0] SUM_ONE = 64'sh0000_0001_0000_0000;

  // Control and pass-through data that travels with each beat.
  typedef struct packed {
    logic               is_req;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
  } item_tag_t;

endpackage

FILE: hdl/pwb_if.sv
// Valid/ready channel interfaces for the input and result streams.
// Depends on pwb_pkg for field widths.
`timescale 1ns / 1ps

interface pwb_in_if;
  import pwb_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [CHAN_W-1:0]  red_in;
  logic [CHAN_W-1:0]  green_in;
  logic [CHAN_W-1:0]  blue_in;

  modport source (output valid, kind, col, row, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, kind, col, row, red_in, green_in, blue_in, output ready);
endinterface

interface pwb_out_if;
  import pwb_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic [CHAN_W-1:0]  red_out;
  logic [CHAN_W-1:0]  green_out;
  logic [CHAN_W-1:0]  blue_out;
  logic               inside_res;

  modport source (output valid, out_col, out_row, red_out, green_out, blue_out, inside_res,
                  input ready);
  modport sink   (input valid, out_col, out_row, red_out, green_out, blue_out, inside_res,
                  output ready);
endinterface

FILE: hdl/perspective_warp_bilinear_unit.sv
// Top level of the perspective warp unit with bilinear sampling.
// Depends on pwb_pkg, pwb_if, pwb_map, pwb_sample and pwb_ram.
//
//   Channel  Direction  Handshake          Beat contents
//   in_ch    input      valid/ready        kind, col, row, red_in, green_in, blue_in
//   out_ch   output     valid/ready        out_col, out_row, colors, inside_res
//   cfg_*    input      write enable only  cfg_idx, cfg_wdata (48-bit coefficient)
//
// One beat is taken every clock while results are drained. After its beat is
// accepted, a request passes the mapping stages, the divider, the bank read,
// the blend stages and the result register; the divider resolves one quotient
// bit per stage for both axes.
// Loads travel the same pipeline and write the image banks at the stage where
// requests read them, so every request sees exactly the loads ahead of it.
// Synchronous reset clears the pipeline valids and sets the coefficients to
// the identity mapping; the image store is not cleared. A stalled result halts
// the pipeline only when a second request has reached the final blend stage.
`timescale 1ns / 1ps

module perspective_warp_bilinear_unit #(
  parameter int SRC_SIZE    = 512,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pwb_in_if.sink                          in_ch,
  pwb_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [pwb_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [pwb_pkg::COEF_W-1:0]      cfg_wdata
);

  import pwb_pkg::*;

  localparam int LOG_S = $clog2(SRC_SIZE);
  localparam int QB    = LOG_S + WEIGHT_BITS;

  // Coefficient bank.
  coef_t coef_r [NUM_COEF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
      coef_r[REG_XX] <= COEF_ONE;
      coef_r[REG_YY] <= COEF_ONE;
    end else if (cfg_we) begin
      coef_r[cfg_idx] <= $signed(cfg_wdata);
    end
  end

  // Input beat packed for the pipeline.
  item_tag_t in_tag;
  logic      adv;

  assign in_tag.is_req = (kind_t'(in_ch.kind) == KIND_REQ);
  assign in_tag.col    = in_ch.col;
  assign in_tag.row    = in_ch.row;
  assign in_tag.red    = in_ch.red_in;
  assign in_tag.green  = in_ch.green_in;
  assign in_tag.blue   = in_ch.blue_in;
  assign in_ch.ready   = adv;

  logic          map_valid;
  item_tag_t     map_tag;
  logic          map_ok;
  logic [QB-1:0] map_qx;
  logic [QB-1:0] map_qy;

  pwb_map #(
    .SRC_SIZE    (SRC_SIZE),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_ch.valid),
    .in_tag    (in_tag),
    .coef      (coef_r),
    .out_valid (map_valid),
    .out_tag   (map_tag),
    .out_ok    (map_ok),
    .out_qx    (map_qx),
    .out_qy    (map_qy)
  );

  pwb_sample #(
    .SRC_SIZE    (SRC_SIZE),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_sample (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (map_valid),
    .in_tag   (map_tag),
    .in_ok    (map_ok),
    .in_qx    (map_qx),
    .in_qy    (map_qy),
    .out_ch   (out_ch)
  );

endmodule

FILE: hdl/pwb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module pwb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/pwb_map.sv
// Coordinate mapping pipeline: homography products, sums, sign fix-up and a
// restoring divider with one quotient bit per stage for both axes.
// Depends on pwb_pkg.
`timescale 1ns / 1ps

module pwb_map #(
  parameter int SRC_SIZE    = 512,
  parameter int WEIGHT_BITS = 8,
  localparam int LOG_S = $clog2(SRC_SIZE),
  localparam int QB    = LOG_S + WEIGHT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  pwb_pkg::item_tag_t  in_tag,
  input  pwb_pkg::coef_t      coef [pwb_pkg::NUM_COEF],
  output logic                out_valid,
  output pwb_pkg::item_tag_t  out_tag,
  output logic                out_ok,
  output logic [QB-1:0]       out_qx,
  output logic [QB-1:0]       out_qy
);

  import pwb_pkg::*;

  localparam int PROD_W = COEF_W + COORD_W + 1;
  localparam int RW     = SUM_W + QB;
  localparam int CMP_W  = SUM_W + LOG_S;

  // Stage 1: the six coefficient products.
  logic                     s1_v_r;
  item_tag_t                s1_tag_r;
  logic signed [PROD_W-1:0] s1_p_r [6];
  logic signed [COORD_W:0]  col_s;
  logic signed [COORD_W:0]  row_s;

  assign col_s = {1'b0, in_tag.col};
  assign row_s = {1'b0, in_tag.row};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
    if (adv) begin
      s1_tag_r  <= in_tag;
      s1_p_r[0] <= PROD_W'(coef[REG_XX]) * PROD_W'(col_s);
      s1_p_r[1] <= PROD_W'(coef[REG_XY]) * PROD_W'(row_s);
      s1_p_r[2] <= PROD_W'(coef[REG_YX]) * PROD_W'(col_s);
      s1_p_r[3] <= PROD_W'(coef[REG_YY]) * PROD_W'(row_s);
      s1_p_r[4] <= PROD_W'(coef[REG_WX]) * PROD_W'(col_s);
      s1_p_r[5] <= PROD_W'(coef[REG_WY]) * PROD_W'(row_s);
    end
  end

  // Stage 2: numerators and denominator.
  logic                    s2_v_r;
  item_tag_t               s2_tag_r;
  logic signed [SUM_W-1:0] s2_nx_r;
  logic signed [SUM_W-1:0] s2_ny_r;
  logic signed [SUM_W-1:0] s2_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
    if (adv) begin
      s2_tag_r <= s1_tag_r;
      s2_nx_r  <= SUM_W'(s1_p_r[0]) + SUM_W'(s1_p_r[1]) + SUM_W'(coef[REG_X0]);
      s2_ny_r  <= SUM_W'(s1_p_r[2]) + SUM_W'(s1_p_r[3]) + SUM_W'(coef[REG_Y0]);
      s2_w_r   <= SUM_W'(s1_p_r[4]) + SUM_W'(s1_p_r[5]) + SUM_ONE;
    end
  end

  // Stage 3: make the denominator non-negative by negating it and both numerators.
  logic                    s3_v_r;
  item_tag_t               s3_tag_r;
  logic signed [SUM_W-1:0] s3_nx_r;
  logic signed [SUM_W-1:0] s3_ny_r;
  logic [SUM_W-1:0]        s3_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
    if (adv) begin
      s3_tag_r <= s2_tag_r;
      if (s2_w_r[SUM_W-1]) begin
        s3_nx_r  <= -s2_nx_r;
        s3_ny_r  <= -s2_ny_r;
        s3_den_r <= $unsigned(-s2_w_r);
      end else begin
        s3_nx_r  <= s2_nx_r;
        s3_ny_r  <= s2_ny_r;
        s3_den_r <= $unsigned(s2_w_r);
      end
    end
  end

  // Divider pipeline, index 0 is the range check stage.
  logic             v_r   [QB+1];
  item_tag_t        tag_r [QB+1];
  logic             ok_r  [QB+1];
  logic [SUM_W-1:0] den_r [QB+1];
  logic [RW-1:0]    rem_r [QB+1][2];
  logic [QB-1:0]    q_r   [QB+1][2];

  // A quotient that fits in QB bits needs num < den * 2^LOG_S.
  logic [CMP_W-1:0] den_lim;
  logic             fit_x;
  logic             fit_y;

  assign den_lim = {s3_den_r, {LOG_S{1'b0}}};
  assign fit_x   = !s3_nx_r[SUM_W-1] && (CMP_W'($unsigned(s3_nx_r)) < den_lim);
  assign fit_y   = !s3_ny_r[SUM_W-1] && (CMP_W'($unsigned(s3_ny_r)) < den_lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= s3_v_r;
    end
    if (adv) begin
      tag_r[0]    <= s3_tag_r;
      ok_r[0]     <= (s3_den_r != '0) && fit_x && fit_y;
      den_r[0]    <= s3_den_r;
      rem_r[0][0] <= RW'({$unsigned(s3_nx_r), {WEIGHT_BITS{1'b0}}});
      rem_r[0][1] <= RW'({$unsigned(s3_ny_r), {WEIGHT_BITS{1'b0}}});
      q_r[0][0]   <= '0;
      q_r[0][1]   <= '0;
    end
  end

  // One compare and subtract per stage, most significant quotient bit first.
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic [RW-1:0] dk;
    logic [1:0]    ge;

    assign dk = RW'(den_r[j]) << K;

    always_comb begin
      for (int a = 0; a < 2; a++) begin
        ge[a] = rem_r[j][a] >= dk;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (adv) begin
        v_r[j+1] <= v_r[j];
      end
      if (adv) begin
        tag_r[j+1] <= tag_r[j];
        ok_r[j+1]  <= ok_r[j];
        den_r[j+1] <= den_r[j];
        for (int a = 0; a < 2; a++) begin
          rem_r[j+1][a] <= ge[a] ? (rem_r[j][a] - dk) : rem_r[j][a];
          q_r[j+1][a]   <= q_r[j][a] | (QB'(ge[a]) << K);
        end
      end
    end
  end

  assign out_valid = v_r[QB];
  assign out_tag   = tag_r[QB];
  assign out_ok    = ok_r[QB];
  assign out_qx    = q_r[QB][0];
  assign out_qy    = q_r[QB][1];

endmodule

FILE: hdl/pwb_sample.sv
// Source image store in four parity banks, bilinear blend and result register.
// Depends on pwb_pkg, pwb_if and pwb_ram.
`timescale 1ns / 1ps

module pwb_sample #(
  parameter int SRC_SIZE    = 512,
  parameter int WEIGHT_BITS = 8,
  localparam int LOG_S = $clog2(SRC_SIZE),
  localparam int QB    = LOG_S + WEIGHT_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  output logic               adv,
  input  logic               in_valid,
  input  pwb_pkg::item_tag_t in_tag,
  input  logic               in_ok,
  input  logic [QB-1:0]      in_qx,
  input  logic [QB-1:0]      in_qy,
  pwb_out_if.source          out_ch
);

  import pwb_pkg::*;

  localparam int HALF  = (SRC_SIZE + 1) / 2;
  localparam int DEPTH = HALF * HALF;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = $clog2(HALF);
  localparam int PIX_W = 3 * CHAN_W;
  localparam int FW    = WEIGHT_BITS + 1;
  localparam int TW    = CHAN_W + WEIGHT_BITS + 1;
  localparam int VW    = CHAN_W + 2 * WEIGHT_BITS + 2;

  // Stage A: split the mapped position and form bank addresses.
  logic [LOG_S-1:0]       ix;
  logic [LOG_S-1:0]       iy;
  logic [WEIGHT_BITS-1:0] dx;
  logic [WEIGHT_BITS-1:0] dy;
  logic                   in_area;
  logic [HW-1:0]          hx [2];
  logic [HW-1:0]          hy [2];
  logic                   ld_ok;
  logic [1:0]             ld_bank;
  logic [AW-1:0]          ld_addr;
  logic [PIX_W-1:0]       ld_data;
  logic [AW-1:0]          raddr [4];
  logic                   re [4];
  logic                   we [4];
  logic [PIX_W-1:0]       rd [4];

  assign ix      = in_qx[QB-1:WEIGHT_BITS];
  assign iy      = in_qy[QB-1:WEIGHT_BITS];
  assign dx      = in_qx[WEIGHT_BITS-1:0];
  assign dy      = in_qy[WEIGHT_BITS-1:0];
  assign in_area = in_ok && (ix < LOG_S'(SRC_SIZE - 1)) && (iy < LOG_S'(SRC_SIZE - 1));

  // Even banks take the neighbor one step on when the position is odd.
  assign hx[1] = HW'(ix >> 1);
  assign hx[0] = HW'(ix >> 1) + HW'(ix[0]);
  assign hy[1] = HW'(iy >> 1);
  assign hy[0] = HW'(iy >> 1) + HW'(iy[0]);

  // Loads outside the image are dropped.
  assign ld_ok   = in_valid && !in_tag.is_req && (int'(in_tag.col) < SRC_SIZE)
                   && (int'(in_tag.row) < SRC_SIZE);
  assign ld_bank = {in_tag.row[0], in_tag.col[0]};
  assign ld_addr = AW'(HW'(in_tag.row >> 1)) * AW'(HALF) + AW'(HW'(in_tag.col >> 1));
  assign ld_data = {in_tag.blue, in_tag.green, in_tag.red};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    assign raddr[b] = AW'(hy[b / 2]) * AW'(HALF) + AW'(hx[b % 2]);
    assign re[b]    = adv && in_valid && in_tag.is_req && in_area;
    assign we[b]    = adv && ld_ok && (ld_bank == 2'(b));

    pwb_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we[b]),
      .waddr (ld_addr),
      .wdata (ld_data),
      .re    (re[b]),
      .raddr (raddr[b]),
      .rdata (rd[b])
    );
  end

  // Stage B: bank data arrives; blend along x.
  logic                   b_v_r;
  item_tag_t              b_tag_r;
  logic                   b_in_r;
  logic                   b_x0_r;
  logic                   b_y0_r;
  logic [WEIGHT_BITS-1:0] b_dx_r;
  logic [WEIGHT_BITS-1:0] b_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= in_valid;
    end
    if (adv) begin
      b_tag_r <= in_tag;
      b_in_r  <= in_area;
      b_x0_r  <= ix[0];
      b_y0_r  <= iy[0];
      b_dx_r  <= dx;
      b_dy_r  <= dy;
    end
  end

  logic [PIX_W-1:0] p00;
  logic [PIX_W-1:0] p10;
  logic [PIX_W-1:0] p01;
  logic [PIX_W-1:0] p11;
  logic [FW-1:0]    wx0;
  logic [FW-1:0]    wx1;
  logic [TW-1:0]    top [3];
  logic [TW-1:0]    bot [3];

  // Pixel (ix+ox, iy+oy) sits in the bank of its own parity.
  assign p00 = rd[{b_y0_r, b_x0_r}];
  assign p10 = rd[{b_y0_r, ~b_x0_r}];
  assign p01 = rd[{~b_y0_r, b_x0_r}];
  assign p11 = rd[{~b_y0_r, ~b_x0_r}];
  assign wx1 = {1'b0, b_dx_r};
  assign wx0 = FW'(1 << WEIGHT_BITS) - wx1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      top[c] = TW'(p00[c*CHAN_W +: CHAN_W]) * TW'(wx0)
             + TW'(p10[c*CHAN_W +: CHAN_W]) * TW'(wx1);
      bot[c] = TW'(p01[c*CHAN_W +: CHAN_W]) * TW'(wx0)
             + TW'(p11[c*CHAN_W +: CHAN_W]) * TW'(wx1);
    end
  end

  // Stage C: blend along y and truncate.
  logic                   c_v_r;
  item_tag_t              c_tag_r;
  logic                   c_in_r;
  logic [WEIGHT_BITS-1:0] c_dy_r;
  logic [TW-1:0]          c_top_r [3];
  logic [TW-1:0]          c_bot_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= b_v_r;
    end
    if (adv) begin
      c_tag_r <= b_tag_r;
      c_in_r  <= b_in_r;
      c_dy_r  <= b_dy_r;
      c_top_r <= top;
      c_bot_r <= bot;
    end
  end

  logic [FW-1:0]     wy0;
  logic [FW-1:0]     wy1;
  logic [VW-1:0]     vsum [3];
  logic [CHAN_W-1:0] color [3];

  assign wy1 = {1'b0, c_dy_r};
  assign wy0 = FW'(1 << WEIGHT_BITS) - wy1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vsum[c]  = VW'(c_top_r[c]) * VW'(wy0) + VW'(c_bot_r[c]) * VW'(wy1);
      color[c] = c_in_r ? vsum[c][2*WEIGHT_BITS +: CHAN_W] : '0;
    end
  end

  // Result register. The pipeline moves unless a request in stage C
  // would overwrite a result that has not been taken.
  logic              out_v_r;
  logic [COORD_W-1:0] out_col_r;
  logic [COORD_W-1:0] out_row_r;
  logic [CHAN_W-1:0] out_red_r;
  logic [CHAN_W-1:0] out_green_r;
  logic [CHAN_W-1:0] out_blue_r;
  logic              out_in_r;
  logic              c_req;

  assign c_req = c_v_r && c_tag_r.is_req;
  assign adv   = !out_v_r || out_ch.ready || !c_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && c_req) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
    if (adv && c_req) begin
      out_col_r   <= c_tag_r.col;
      out_row_r   <= c_tag_r.row;
      out_red_r   <= color[0];
      out_green_r <= color[1];
      out_blue_r  <= color[2];
      out_in_r    <= c_in_r;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_col    = out_col_r;
  assign out_ch.out_row    = out_row_r;
  assign out_ch.red_out    = out_red_r;
  assign out_ch.green_out  = out_green_r;
  assign out_ch.blue_out   = out_blue_r;
  assign out_ch.inside_res = out_in_r;

endmodule
